### src/aps_pkg.sv
package aps_pkg;

  localparam int ENTRY_IDX_W = 6;
  localparam int BASE_W      = 31;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 7;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic                   req_type;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [BASE_W-1:0]      base_value;
  } in_item_t;

  typedef struct packed {
    logic                   is_grant;
    logic [ENTRY_IDX_W-1:0] granted_index;
    logic [COUNT_W-1:0]     grant_count;
  } out_item_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic load;
    logic update;
  } cell_ctl_t;

  // Flags of the scan token that walks down the chain.
  typedef struct packed {
    logic go;
    logic have;
  } tok_flags_t;

endpackage

### src/aging_priority_selector.sv
// Aging priority selector. Each entry of the table lives in its own cell of a
// chain. A load transaction writes one entry and is acknowledged at once; the
// next transaction can be taken in the following cycle unless the output is
// stalled. A tick sends a token down the chain, one cell per cycle, carrying
// the best entry seen so far; the winner is captured as the token leaves the
// last cell. Once the output is free, the winner is reset to its base, every
// other entry in use is aged in one broadcast and the grant is registered.
// Entries at or above entries_in_use let the token pass untouched. The result
// register holds a finished transaction while the output is stalled; a tick
// that finishes then waits for it.
module aging_priority_selector #(
  parameter int MAX_ENTRIES = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aps_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aps_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SAT_W = (VALUE_BITS > aps_pkg::BASE_W) ? VALUE_BITS : aps_pkg::BASE_W;
  localparam logic [SAT_W-1:0] VAL_MAX = SAT_W'({VALUE_BITS{1'b1}});

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [aps_pkg::CFG_W-1:0]   cfg_r;
  logic                        out_valid_r, out_valid_nxt;
  aps_pkg::out_item_t          out_r, out_nxt;
  logic [IDX_W-1:0]            gidx_r, gidx_nxt;
  logic [aps_pkg::COUNT_W-1:0] gcnt_r, gcnt_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  start;
  aps_pkg::cell_ctl_t    ctl;
  logic [CNT_W-1:0]      n_act;
  logic [SAT_W-1:0]      base_ext;
  logic [VALUE_BITS-1:0] ld_val;

  aps_pkg::tok_flags_t         tok_f [MAX_ENTRIES+1];
  logic [VALUE_BITS-1:0]       tok_v [MAX_ENTRIES+1];
  logic [IDX_W-1:0]            tok_i [MAX_ENTRIES+1];
  logic [aps_pkg::COUNT_W-1:0] tok_c [MAX_ENTRIES+1];

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign start     = in_acc && (in_data.req_type == aps_pkg::REQ_TICK);
  assign cfg_ready = 1'b1;

  always_comb begin
    int nc;
    nc = int'(cfg_r);
    if (nc == 0) nc = 1;
    if (nc > MAX_ENTRIES) nc = MAX_ENTRIES;
    n_act = CNT_W'(nc);
  end

  assign base_ext = SAT_W'(in_data.base_value);
  assign ld_val   = (base_ext > VAL_MAX) ? '1 : VALUE_BITS'(base_ext);

  assign ctl.load   = in_acc && (in_data.req_type == aps_pkg::REQ_LOAD);
  assign ctl.update = (state_r == ST_DONE) && out_free;

  // Seed the chain with an empty token.
  assign tok_f[0].go   = start;
  assign tok_f[0].have = 1'b0;
  assign tok_v[0]      = '0;
  assign tok_i[0]      = '0;
  assign tok_c[0]      = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    aps_cell #(
      .INDEX      (g),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .n_act       (n_act),
      .ld_idx      (in_data.entry_index),
      .ld_val      (ld_val),
      .upd_idx     (gidx_r),
      .tok_in      (tok_f[g]),
      .tok_in_val  (tok_v[g]),
      .tok_in_idx  (tok_i[g]),
      .tok_in_cnt  (tok_c[g]),
      .tok_out     (tok_f[g+1]),
      .tok_out_val (tok_v[g+1]),
      .tok_out_idx (tok_i[g+1]),
      .tok_out_cnt (tok_c[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    gidx_nxt      = gidx_r;
    gcnt_nxt      = gcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.load) begin
          out_valid_nxt         = 1'b1;
          out_nxt.is_grant      = 1'b0;
          out_nxt.granted_index = '0;
          out_nxt.grant_count   = '0;
        end else if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Capture the winner as the token leaves the last cell.
        if (tok_f[MAX_ENTRIES].go) begin
          gidx_nxt  = tok_i[MAX_ENTRIES];
          gcnt_nxt  = tok_c[MAX_ENTRIES];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.is_grant      = 1'b1;
          out_nxt.granted_index = aps_pkg::ENTRY_IDX_W'(gidx_r);
          out_nxt.grant_count   = gcnt_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= aps_pkg::CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    gidx_r <= gidx_nxt;
    gcnt_r <= gcnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/aps_cell.sv
module aps_cell #(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  aps_pkg::cell_ctl_t              ctl,
  input  logic [CNT_W-1:0]                n_act,
  input  logic [aps_pkg::ENTRY_IDX_W-1:0] ld_idx,
  input  logic [VALUE_BITS-1:0]           ld_val,
  input  logic [IDX_W-1:0]                upd_idx,
  input  aps_pkg::tok_flags_t             tok_in,
  input  logic [VALUE_BITS-1:0]           tok_in_val,
  input  logic [IDX_W-1:0]                tok_in_idx,
  input  logic [aps_pkg::COUNT_W-1:0]     tok_in_cnt,
  output aps_pkg::tok_flags_t             tok_out,
  output logic [VALUE_BITS-1:0]           tok_out_val,
  output logic [IDX_W-1:0]                tok_out_idx,
  output logic [aps_pkg::COUNT_W-1:0]     tok_out_cnt
);

  logic [VALUE_BITS-1:0]       base_r, base_nxt;
  logic [VALUE_BITS-1:0]       cur_r, cur_nxt;
  logic [aps_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  aps_pkg::tok_flags_t         tok_r, tok_nxt;
  logic [VALUE_BITS-1:0]       tval_r, tval_nxt;
  logic [IDX_W-1:0]            tidx_r, tidx_nxt;
  logic [aps_pkg::COUNT_W-1:0] tcnt_r, tcnt_nxt;

  logic                        act;
  logic                        take;
  logic [VALUE_BITS-1:0]       cur_inc;
  logic [aps_pkg::COUNT_W-1:0] cnt_inc;

  assign act     = INDEX < int'(n_act);
  assign cur_inc = (cur_r == '1) ? cur_r : cur_r + VALUE_BITS'(1);
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + aps_pkg::COUNT_W'(1);
  // Strictly greater: an earlier entry keeps the token on a tie.
  assign take    = act && (!tok_in.have || (cur_r > tok_in_val));

  always_comb begin
    tok_nxt.go   = tok_in.go;
    tok_nxt.have = tok_in.have;
    tval_nxt     = tok_in_val;
    tidx_nxt     = tok_in_idx;
    tcnt_nxt     = tok_in_cnt;
    if (take) begin
      tok_nxt.have = 1'b1;
      tval_nxt     = cur_r;
      tidx_nxt     = IDX_W'(INDEX);
      tcnt_nxt     = cnt_inc;
    end
  end

  always_comb begin
    base_nxt = base_r;
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    priority if (ctl.load && (int'(ld_idx) == INDEX)) begin
      base_nxt = ld_val;
      cur_nxt  = ld_val;
    end else if (ctl.update && act) begin
      if (upd_idx == IDX_W'(INDEX)) begin
        cur_nxt = base_r;
        cnt_nxt = cnt_inc;
      end else begin
        cur_nxt = cur_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      cur_r  <= '0;
      cnt_r  <= '0;
      tok_r  <= '0;
    end else begin
      base_r <= base_nxt;
      cur_r  <= cur_nxt;
      cnt_r  <= cnt_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tval_r <= tval_nxt;
    tidx_r <= tidx_nxt;
    tcnt_r <= tcnt_nxt;
  end

  assign tok_out     = tok_r;
  assign tok_out_val = tval_r;
  assign tok_out_idx = tidx_r;
  assign tok_out_cnt = tcnt_r;

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH     = 64;
  localparam int SLOT_W          = aps_pkg::ENTRY_IDX_W;
  localparam int TICK_CYCLES     = TABLE_DEPTH + 2;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 60;
  localparam logic [aps_pkg::BASE_W-1:0] BASE_MAX = '1;

  typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [aps_pkg::ENTRY_IDX_W-1:0] index;
    logic [aps_pkg::BASE_W-1:0]      value;
    bit                              typed;
    aps_pkg::out_item_t              result;
  } directed_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  aps_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  aps_pkg::out_item_t          out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [aps_pkg::CFG_W-1:0]   cfg_data = '0;

  // Arbiter shadow state
  logic [31:0]                 base_pri [TABLE_DEPTH];
  logic [31:0]                 cur_pri [TABLE_DEPTH];
  logic [aps_pkg::COUNT_W-1:0] grants [TABLE_DEPTH];
  logic [aps_pkg::CFG_W-1:0]   entry_count;

  aps_pkg::out_item_t awaited_replies[$];
  bit                 failed = 1'b0;
  bit                 quiet = 1'b0;
  bit                 hold_off_req = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{ROW_TICK, 6'd0,  31'd0,          1'b1, '{1'b1, 6'd0, 32'd1}},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_LOAD, 6'd63, BASE_MAX,       1'b1, '{1'b0, 6'd0, 32'd0}},
    '{ROW_TICK, 6'd0,  31'd0,          1'b1, '{1'b1, 6'd63, 32'd1}},
    '{ROW_TICK, 6'd0,  31'd0,          1'b1, '{1'b1, 6'd63, 32'd2}},
    '{ROW_LOAD, 6'd63, 31'd0,          1'b1, '{1'b0, 6'd0, 32'd0}},
    '{ROW_LOAD, 6'd42, 31'h5555_5555,  1'b0, '0},
    '{ROW_LOAD, 6'd21, 31'h2AAA_AAAA,  1'b0, '0},
    '{ROW_TICK, 6'd21, BASE_MAX,       1'b0, '0},
    '{ROW_TICK, 6'd63, 31'h2AAA_AAAA,  1'b0, '0},
    '{ROW_CFG,  6'd0,  31'd0,          1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b1, '{1'b1, 6'd0, 32'd2}},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_LOAD, 6'd5,  31'h0000_1000,  1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_CFG,  6'd0,  31'd127,        1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_CFG,  6'd0,  31'd6,          1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_LOAD, 6'd0,  BASE_MAX,       1'b0, '0},
    '{ROW_LOAD, 6'd1,  BASE_MAX,       1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_TICK, 6'd0,  31'd0,          1'b0, '0},
    '{ROW_CFG,  6'd0,  31'd64,         1'b0, '0},
    '{ROW_LOAD, 6'd63, 31'd0,          1'b0, '0}
  };

  aging_priority_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned live_entries();
    if (entry_count == 0) return 1;
    if (entry_count > TABLE_DEPTH) return TABLE_DEPTH;
    return 32'(entry_count);
  endfunction

  // Apply one request to the shadow table and return the reply it earns.
  function automatic aps_pkg::out_item_t arbitrate(aps_pkg::in_item_t req);
    aps_pkg::out_item_t reply;
    int unsigned        n;
    int unsigned        best;
    reply = '0;
    if (req.req_type == aps_pkg::REQ_LOAD) begin
      base_pri[req.entry_index] = {1'b0, req.base_value};
      cur_pri[req.entry_index]  = {1'b0, req.base_value};
      return reply;
    end
    n    = live_entries();
    best = 0;
    for (int unsigned k = 1; k < n; k++) begin
      if (cur_pri[k[SLOT_W-1:0]] > cur_pri[best[SLOT_W-1:0]]) best = k;
    end
    for (int unsigned k = 0; k < n; k++) begin
      if (k != best && cur_pri[k[SLOT_W-1:0]] != '1) begin
        cur_pri[k[SLOT_W-1:0]] = cur_pri[k[SLOT_W-1:0]] + 1;
      end
    end
    cur_pri[best[SLOT_W-1:0]] = base_pri[best[SLOT_W-1:0]];
    if (grants[best[SLOT_W-1:0]] != '1) begin
      grants[best[SLOT_W-1:0]] = grants[best[SLOT_W-1:0]] + 1;
    end
    reply.is_grant      = 1'b1;
    reply.granted_index = best[SLOT_W-1:0];
    reply.grant_count   = grants[best[SLOT_W-1:0]];
    return reply;
  endfunction

  function automatic aps_pkg::in_item_t random_request();
    aps_pkg::in_item_t req;
    int unsigned       pick;
    req.req_type = ($urandom_range(0, 99) < 55) ? aps_pkg::REQ_TICK : aps_pkg::REQ_LOAD;
    if ($urandom_range(0, 3) != 0) begin
      req.entry_index = SLOT_W'($urandom_range(0, live_entries() - 1));
    end else begin
      req.entry_index = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    end
    pick = $urandom_range(0, 9);
    if (pick < 4)       req.base_value = aps_pkg::BASE_W'($urandom_range(0, 40));
    else if (pick < 7)  req.base_value = aps_pkg::BASE_W'($urandom_range(0, 5000));
    else if (pick < 9)  req.base_value = aps_pkg::BASE_W'($urandom());
    else                req.base_value = $urandom_range(0, 1) ? BASE_MAX : '0;
    return req;
  endfunction

  task automatic offer(aps_pkg::in_item_t req, bit typed, aps_pkg::out_item_t typed_reply);
    aps_pkg::out_item_t reply;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reply = arbitrate(req);
    awaited_replies.push_back(typed ? typed_reply : reply);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Every request earns a reply, so an empty queue means the block is idle.
  task automatic set_entry_count(logic [aps_pkg::CFG_W-1:0] count);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    entry_count  = count;
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    aps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with nothing awaited: %p", out_data);
        failed = 1'b1;
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.is_grant !== want.is_grant) begin
          $error("is_grant: expected %0d, got %0d", want.is_grant, out_data.is_grant);
          failed = 1'b1;
        end
        if (out_data.granted_index !== want.granted_index) begin
          $error("granted_index: expected %0d, got %0d",
                 want.granted_index, out_data.granted_index);
          failed = 1'b1;
        end
        if (out_data.grant_count !== want.grant_count) begin
          $error("grant_count: expected %0d, got %0d",
                 want.grant_count, out_data.grant_count);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    aps_pkg::in_item_t         req;
    logic [aps_pkg::CFG_W-1:0] settings [10];
    settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd37, 7'd63, 7'd0, 7'd0, 7'd64};
    settings[7] = aps_pkg::CFG_W'($urandom_range(0, 127));
    settings[8] = aps_pkg::CFG_W'($urandom_range(3, 63));
    foreach (base_pri[i]) begin
      base_pri[i] = '0;
      cur_pri[i]  = '0;
      grants[i]   = '0;
    end
    entry_count = aps_pkg::CFG_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_entry_count(directed_rows[i].value[aps_pkg::CFG_W-1:0]);
      end else begin
        req.req_type    = (directed_rows[i].kind == ROW_TICK) ? aps_pkg::REQ_TICK
                                                              : aps_pkg::REQ_LOAD;
        req.entry_index = directed_rows[i].index;
        req.base_value  = directed_rows[i].value;
        offer(req, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    foreach (settings[p]) begin
      set_entry_count(settings[p]);
      // Back up the block once while requests keep coming.
      if (p == 2) hold_off_req = 1'b1;
      if (p == 9) quiet = 1'b1;
      repeat (PHASE_ITEMS) offer(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (TICK_CYCLES + 4) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### aging_priority_selector.f
src/aps_pkg.sv
src/aps_cell.sv
src/aging_priority_selector.sv
test/tb.sv
